/* sv/crc8_packet_receiver_with_ring_defines.svh */
// Assertion macros for the CRC-8 packet receiver.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef CRC8_PACKET_RECEIVER_WITH_RING_DEFINES_SVH
`define CRC8_PACKET_RECEIVER_WITH_RING_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cpr assertion failed");
`define CPR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cpr assertion failed");
`else
`define CPR_ASSERT(lbl, prop)
`define CPR_ASSERT_RST(lbl, prop)
`endif

`endif

/* sv/cpr_pkg.sv */
// Types, constants and helper functions of the CRC-8 packet receiver.
// Depends on nothing; used by crc8_packet_receiver_with_ring.
package cpr_pkg;

  localparam int RING_DEPTH = 10;
  localparam int DATA_MAX   = 16;

  localparam int SLOT_BYTES = DATA_MAX + 3;
  localparam int NUM_SLOTS  = RING_DEPTH + 1;
  localparam int MEM_DEPTH  = NUM_SLOTS * SLOT_BYTES;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int OFF_W  = $clog2(SLOT_BYTES);
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam off_t OFF_ID   = off_t'(0);
  localparam off_t OFF_LEN  = off_t'(1);
  localparam off_t OFF_CRC  = off_t'(2);
  localparam off_t OFF_DATA = off_t'(3);

  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_ACK     = 8'h15;
  localparam logic [7:0] CRC_RETX    = 8'h12;
  localparam logic [7:0] CRC_GIVEUP  = 8'hE6;
  localparam logic [7:0] CODE_ACK    = 8'h00;
  localparam logic [7:0] CODE_RETX   = 8'h01;
  localparam logic [7:0] CODE_GIVEUP = 8'hFF;
  localparam logic [7:0] CTL_LEN     = 8'h01;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLY,
    ST_POP,
    ST_EMPTY
  } state_e;

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_CRC
  } phase_e;

  typedef enum logic [1:0] {
    LR_NONE,
    LR_ACK,
    LR_GIVEUP
  } last_e;

  typedef enum logic [1:0] {
    RP_ACK,
    RP_RETX,
    RP_GIVEUP,
    RP_ZERO
  } reply_e;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic slot_t slot_inc(slot_t s);
    return (s == slot_t'(NUM_SLOTS - 1)) ? '0 : slot_t'(s + slot_t'(1));
  endfunction

  function automatic logic [7:0] reply_byte(reply_e r, logic [1:0] idx);
    logic [7:0] v;
    v = 8'h00;
    unique case (idx)
      2'd0: v = 8'h00;
      2'd1: v = (r == RP_ZERO) ? 8'h00 : CTL_LEN;
      2'd2: begin
        unique case (r)
          RP_ACK:    v = CODE_ACK;
          RP_RETX:   v = CODE_RETX;
          RP_GIVEUP: v = CODE_GIVEUP;
          RP_ZERO:   v = 8'h00;
        endcase
      end
      2'd3: begin
        unique case (r)
          RP_ACK:    v = CRC_ACK;
          RP_RETX:   v = CRC_RETX;
          RP_GIVEUP: v = CRC_GIVEUP;
          RP_ZERO:   v = 8'h00;
        endcase
      end
    endcase
    return v;
  endfunction

endpackage

/* sv/crc8_packet_receiver_with_ring.sv */
// Top level of the CRC-8 framed packet receiver with its ring of packets.
// Depends on cpr_pkg and crc8_packet_receiver_with_ring_defines.svh.
//
// Input words carry func_i and rx_byte_i. A line byte (func_i low) is taken
// while the block is idle; the closing CRC byte of a frame starts a reply of
// three or four words, unless it closes a valid ack control frame, which is
// dropped. Reply words are sent one per cycle while out_ready_i is high.
// A pop (func_i high) returns the oldest stored packet, id, length, data and
// CRC, or a single ring-empty word. Popped words are read through the one
// read port of the packet memory, and the data words and CRC wait for the
// stored length byte. out_last_o marks the final word of each item. A new
// input word is taken as soon as the previous item's last word sits in the
// output register. When the receiver stalls, the output register holds its
// word and the block waits. Reset empties the ring, clears the frame state
// and the retry count and sets max_retries to five; the packet memory is not
// cleared. max_retries is written through the APB port.
`include "crc8_packet_receiver_with_ring_defines.svh"

module crc8_packet_receiver_with_ring (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cpr_pkg::state_e st_q, st_d;
  cpr_pkg::phase_e phase_q, phase_d;
  cpr_pkg::last_e  last_q, last_d;
  cpr_pkg::reply_e reply_q, reply_d;
  logic [7:0]      id_q, id_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      dc_q, dc_d;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      data0_q, data0_d;
  logic [7:0]      retry_q, retry_d;
  logic [7:0]      maxr_q, maxr_d;
  logic [1:0]      rcnt_q, rcnt_d;
  cpr_pkg::slot_t  head_q, head_d;
  cpr_pkg::slot_t  tail_q, tail_d;
  cpr_pkg::slot_t  rslot_q, rslot_d;
  cpr_pkg::cnt_t   cnt_q, cnt_d;
  cpr_pkg::off_t   pos_q, pos_d;
  cpr_pkg::off_t   lastpos_q, lastpos_d;
  logic            len_ok_q, len_ok_d;
  logic            len_wait_q, len_wait_d;
  logic            issued_all_q, issued_all_d;
  logic            pend_q, pend_d;
  logic            pend_last_q, pend_last_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_kind_q, out_kind_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;

  logic [7:0]      mem_q [cpr_pkg::MEM_DEPTH];
  logic [7:0]      rdata_q;

  logic            we, re, ld_out, in_acc, out_free, move, reply_end, cfg_wr, last_issue;
  cpr_pkg::off_t   woff, roff;
  cpr_pkg::addr_t  waddr, raddr;
  logic [7:0]      crc_next, keep;

  assign in_ready_o  = (st_q == cpr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign pready      = 1'b1;
  assign prdata      = paddr[2] ? 32'h0 : {24'h0, maxr_q};
  assign cfg_wr      = psel && penable && pwrite && !paddr[2];

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign move     = pend_q && out_free;
  assign crc_next = cpr_pkg::crc8_update((phase_q == cpr_pkg::PH_ID) ? 8'h00 : crc_q,
                                         rx_byte_i);
  assign keep     = ({1'b0, rdata_q} < 9'(cpr_pkg::DATA_MAX)) ? rdata_q
                                                               : 8'(cpr_pkg::DATA_MAX);
  assign reply_end  = (rcnt_q == 2'd3) || (reply_q == cpr_pkg::RP_ZERO && rcnt_q == 2'd2);
  assign last_issue = len_ok_q && (pos_q == lastpos_q);

  assign waddr = cpr_pkg::addr_t'(cpr_pkg::addr_t'(head_q)
                 * cpr_pkg::addr_t'(cpr_pkg::SLOT_BYTES)) + cpr_pkg::addr_t'(woff);
  assign raddr = cpr_pkg::addr_t'(cpr_pkg::addr_t'(rslot_q)
                 * cpr_pkg::addr_t'(cpr_pkg::SLOT_BYTES)) + cpr_pkg::addr_t'(roff);

  always_comb begin
    st_d         = st_q;
    phase_d      = phase_q;
    last_d       = last_q;
    reply_d      = reply_q;
    id_d         = id_q;
    len_d        = len_q;
    dc_d         = dc_q;
    crc_d        = crc_q;
    data0_d      = data0_q;
    retry_d      = retry_q;
    maxr_d       = maxr_q;
    rcnt_d       = rcnt_q;
    head_d       = head_q;
    tail_d       = tail_q;
    rslot_d      = rslot_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    lastpos_d    = lastpos_q;
    len_ok_d     = len_ok_q;
    len_wait_d   = len_wait_q;
    issued_all_d = issued_all_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    we           = 1'b0;
    re           = 1'b0;
    ld_out       = 1'b0;
    woff         = cpr_pkg::OFF_ID;
    roff         = cpr_pkg::OFF_ID;

    unique case (st_q)
      cpr_pkg::ST_IDLE: begin
        if (in_acc && func_i) begin
          if (cnt_q == '0) begin
            st_d = cpr_pkg::ST_EMPTY;
          end else begin
            rslot_d      = tail_q;
            tail_d       = cpr_pkg::slot_inc(tail_q);
            cnt_d        = cpr_pkg::cnt_t'(cnt_q - cpr_pkg::cnt_t'(1));
            pos_d        = '0;
            len_ok_d     = 1'b0;
            len_wait_d   = 1'b0;
            issued_all_d = 1'b0;
            st_d         = cpr_pkg::ST_POP;
          end
        end else if (in_acc) begin
          unique case (phase_q)
            cpr_pkg::PH_ID: begin
              id_d    = rx_byte_i;
              crc_d   = crc_next;
              we      = 1'b1;
              woff    = cpr_pkg::OFF_ID;
              phase_d = cpr_pkg::PH_LEN;
            end
            cpr_pkg::PH_LEN: begin
              len_d   = rx_byte_i;
              crc_d   = crc_next;
              dc_d    = '0;
              we      = 1'b1;
              woff    = cpr_pkg::OFF_LEN;
              phase_d = (rx_byte_i == 8'h00) ? cpr_pkg::PH_CRC : cpr_pkg::PH_DATA;
            end
            cpr_pkg::PH_DATA: begin
              if ({1'b0, dc_q} < 9'(cpr_pkg::DATA_MAX)) begin
                we   = 1'b1;
                woff = cpr_pkg::off_t'(cpr_pkg::off_t'(dc_q) + cpr_pkg::OFF_DATA);
              end
              if (dc_q == 8'h00) begin
                data0_d = rx_byte_i;
              end
              crc_d = crc_next;
              dc_d  = 8'(dc_q + 8'd1);
              if ((9'(dc_q) + 9'd1) >= {1'b0, len_q}) begin
                phase_d = cpr_pkg::PH_CRC;
              end
            end
            cpr_pkg::PH_CRC: begin
              phase_d = cpr_pkg::PH_ID;
              rcnt_d  = 2'd0;
              if (rx_byte_i == crc_q) begin
                if (id_q == 8'h00 && len_q == cpr_pkg::CTL_LEN
                    && data0_q == cpr_pkg::CODE_ACK) begin
                  st_d = cpr_pkg::ST_IDLE;
                end else if (id_q == 8'h00 && len_q == cpr_pkg::CTL_LEN
                             && data0_q == cpr_pkg::CODE_RETX) begin
                  st_d = cpr_pkg::ST_REPLY;
                  if (last_q == cpr_pkg::LR_ACK) begin
                    reply_d = cpr_pkg::RP_ACK;
                  end else if (last_q == cpr_pkg::LR_GIVEUP) begin
                    reply_d = cpr_pkg::RP_GIVEUP;
                  end else begin
                    reply_d = cpr_pkg::RP_ZERO;
                  end
                end else begin
                  we   = 1'b1;
                  woff = cpr_pkg::OFF_CRC;
                  if (cnt_q == cpr_pkg::cnt_t'(cpr_pkg::RING_DEPTH)) begin
                    tail_d = cpr_pkg::slot_inc(tail_q);
                  end else begin
                    cnt_d = cpr_pkg::cnt_t'(cnt_q + cpr_pkg::cnt_t'(1));
                  end
                  head_d  = cpr_pkg::slot_inc(head_q);
                  last_d  = cpr_pkg::LR_ACK;
                  reply_d = cpr_pkg::RP_ACK;
                  st_d    = cpr_pkg::ST_REPLY;
                end
              end else if (retry_q < maxr_q) begin
                retry_d = 8'(retry_q + 8'd1);
                reply_d = cpr_pkg::RP_RETX;
                st_d    = cpr_pkg::ST_REPLY;
              end else begin
                retry_d = '0;
                last_d  = cpr_pkg::LR_GIVEUP;
                reply_d = cpr_pkg::RP_GIVEUP;
                st_d    = cpr_pkg::ST_REPLY;
              end
            end
          endcase
        end
      end
      cpr_pkg::ST_REPLY: begin
        if (out_free) begin
          ld_out     = 1'b1;
          out_kind_d = cpr_pkg::KIND_TX;
          out_byte_d = cpr_pkg::reply_byte(reply_q, rcnt_q);
          out_last_d = reply_end;
          rcnt_d     = 2'(rcnt_q + 2'd1);
          if (reply_end) begin
            st_d = cpr_pkg::ST_IDLE;
          end
        end
      end
      cpr_pkg::ST_EMPTY: begin
        if (out_free) begin
          ld_out     = 1'b1;
          out_kind_d = cpr_pkg::KIND_EMPTY;
          out_byte_d = 8'h00;
          out_last_d = 1'b1;
          st_d       = cpr_pkg::ST_IDLE;
        end
      end
      cpr_pkg::ST_POP: begin
        if (len_wait_q) begin
          len_wait_d = 1'b0;
          len_ok_d   = 1'b1;
          lastpos_d  = cpr_pkg::off_t'(cpr_pkg::off_t'(keep) + cpr_pkg::off_t'(2));
        end
        if (move) begin
          ld_out     = 1'b1;
          out_kind_d = cpr_pkg::KIND_POP;
          out_byte_d = rdata_q;
          out_last_d = pend_last_q;
          pend_d     = 1'b0;
          if (pend_last_q) begin
            st_d = cpr_pkg::ST_IDLE;
          end
        end
        if (!issued_all_q && (pos_q < cpr_pkg::off_t'(2) || len_ok_q)
            && (!pend_q || move)) begin
          re          = 1'b1;
          pend_d      = 1'b1;
          pend_last_d = last_issue;
          pos_d       = cpr_pkg::off_t'(pos_q + cpr_pkg::off_t'(1));
          if (pos_q == cpr_pkg::OFF_ID) begin
            roff = cpr_pkg::OFF_ID;
          end else if (pos_q == cpr_pkg::OFF_LEN) begin
            roff       = cpr_pkg::OFF_LEN;
            len_wait_d = 1'b1;
          end else if (last_issue) begin
            roff         = cpr_pkg::OFF_CRC;
            issued_all_d = 1'b1;
          end else begin
            roff = cpr_pkg::off_t'(pos_q + cpr_pkg::off_t'(1));
          end
        end
      end
    endcase

    if (ld_out) begin
      out_valid_d = 1'b1;
    end
    if (cfg_wr) begin
      maxr_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= cpr_pkg::ST_IDLE;
      phase_q      <= cpr_pkg::PH_ID;
      last_q       <= cpr_pkg::LR_NONE;
      reply_q      <= cpr_pkg::RP_ACK;
      id_q         <= '0;
      len_q        <= '0;
      dc_q         <= '0;
      crc_q        <= '0;
      data0_q      <= '0;
      retry_q      <= '0;
      maxr_q       <= 8'd5;
      rcnt_q       <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      rslot_q      <= '0;
      cnt_q        <= '0;
      pos_q        <= '0;
      lastpos_q    <= '0;
      len_ok_q     <= 1'b0;
      len_wait_q   <= 1'b0;
      issued_all_q <= 1'b0;
      pend_q       <= 1'b0;
      pend_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= '0;
      out_byte_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      st_q         <= st_d;
      phase_q      <= phase_d;
      last_q       <= last_d;
      reply_q      <= reply_d;
      id_q         <= id_d;
      len_q        <= len_d;
      dc_q         <= dc_d;
      crc_q        <= crc_d;
      data0_q      <= data0_d;
      retry_q      <= retry_d;
      maxr_q       <= maxr_d;
      rcnt_q       <= rcnt_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      rslot_q      <= rslot_d;
      cnt_q        <= cnt_d;
      pos_q        <= pos_d;
      lastpos_q    <= lastpos_d;
      len_ok_q     <= len_ok_d;
      len_wait_q   <= len_wait_d;
      issued_all_q <= issued_all_d;
      pend_q       <= pend_d;
      pend_last_q  <= pend_last_d;
      out_valid_q  <= out_valid_d;
      out_kind_q   <= out_kind_d;
      out_byte_q   <= out_byte_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= rx_byte_i;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  `CPR_ASSERT_RST(a_cnt_bound, !rst_ni || (cnt_q <= cpr_pkg::cnt_t'(cpr_pkg::RING_DEPTH)))
  `CPR_ASSERT(a_head_tail, (cnt_q == '0) == (head_q == tail_q))
  `CPR_ASSERT(a_out_free, ld_out |-> (!out_valid_q || out_ready_i))
  `CPR_ASSERT(a_pend_pop, pend_q |-> (st_q == cpr_pkg::ST_POP))
  `CPR_ASSERT(a_mem_port, !(we && re))

endmodule

/* tb/tb_crc8_packet_receiver_with_ring.sv */
`timescale 1ns / 1ps
// Self-checking testbench for crc8_packet_receiver_with_ring: framed line bytes and
// pops are driven over valid/ready and replies and popped words checked in order.
// Depends on cpr_pkg and the RTL of the block; holds its own predictor in a scoreboard.

typedef struct packed {
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;
} out_word_t;

function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b);
  logic [7:0] r;
  r = acc ^ b;
  repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ cpr_pkg::CRC_POLY) : {r[6:0], 1'b0};
  return r;
endfunction

class packet_ring_scoreboard;
  out_word_t       expected_words[$];
  logic [7:0]      max_retries;
  cpr_pkg::phase_e rx_phase;
  logic [7:0]      frame_id, frame_len, data_count, running_crc, retry_count;
  logic [7:0]      staging[cpr_pkg::DATA_MAX];
  cpr_pkg::last_e  last_reply;
  logic [7:0]      ring_mem[cpr_pkg::RING_DEPTH][cpr_pkg::SLOT_BYTES];
  int ring_head, ring_tail, ring_count;
  int errors, words_in, words_out;
  int n_ack, n_retx, n_giveup, n_replay, n_dropped, n_pop, n_empty;

  function new();
    max_retries = 8'd5;
    rx_phase    = cpr_pkg::PH_ID;
    frame_id    = '0;
    frame_len   = '0;
    data_count  = '0;
    running_crc = '0;
    retry_count = '0;
    last_reply  = cpr_pkg::LR_NONE;
    ring_head   = 0;
    ring_tail   = 0;
    ring_count  = 0;
  endfunction

  function void push(logic [1:0] kind, logic [7:0] data, logic last);
    expected_words.push_back(out_word_t'({kind, data, last}));
  endfunction

  function void push_reply(logic [7:0] code, logic [7:0] crc);
    push(cpr_pkg::KIND_TX, 8'h00, 1'b0);
    push(cpr_pkg::KIND_TX, cpr_pkg::CTL_LEN, 1'b0);
    push(cpr_pkg::KIND_TX, code, 1'b0);
    push(cpr_pkg::KIND_TX, crc, 1'b1);
  endfunction

  function void store_frame(logic [7:0] crc);
    int keep, i;
    if (ring_count >= cpr_pkg::RING_DEPTH) ring_tail = (ring_tail + 1) % cpr_pkg::RING_DEPTH;
    else ring_count++;
    ring_mem[ring_head][cpr_pkg::OFF_ID]  = frame_id;
    ring_mem[ring_head][cpr_pkg::OFF_LEN] = frame_len;
    ring_mem[ring_head][cpr_pkg::OFF_CRC] = crc;
    keep = (frame_len < cpr_pkg::DATA_MAX) ? frame_len : cpr_pkg::DATA_MAX;
    for (i = 0; i < keep; i++) ring_mem[ring_head][cpr_pkg::OFF_DATA + i] = staging[i];
    ring_head = (ring_head + 1) % cpr_pkg::RING_DEPTH;
  endfunction

  function void pop_oldest();
    int keep, i;
    if (ring_count == 0) begin
      push(cpr_pkg::KIND_EMPTY, 8'h00, 1'b1);
      n_empty++;
      return;
    end
    push(cpr_pkg::KIND_POP, ring_mem[ring_tail][cpr_pkg::OFF_ID], 1'b0);
    push(cpr_pkg::KIND_POP, ring_mem[ring_tail][cpr_pkg::OFF_LEN], 1'b0);
    keep = (ring_mem[ring_tail][cpr_pkg::OFF_LEN] < cpr_pkg::DATA_MAX)
           ? ring_mem[ring_tail][cpr_pkg::OFF_LEN] : cpr_pkg::DATA_MAX;
    for (i = 0; i < keep; i++) begin
      push(cpr_pkg::KIND_POP, ring_mem[ring_tail][cpr_pkg::OFF_DATA + i], 1'b0);
    end
    push(cpr_pkg::KIND_POP, ring_mem[ring_tail][cpr_pkg::OFF_CRC], 1'b1);
    ring_tail = (ring_tail + 1) % cpr_pkg::RING_DEPTH;
    ring_count--;
    n_pop++;
  endfunction

  function void close_frame(logic [7:0] b);
    logic ctl;
    ctl = (frame_id == 8'h00) && (frame_len == cpr_pkg::CTL_LEN);
    if (b == running_crc) begin
      if (ctl && staging[0] == cpr_pkg::CODE_ACK) begin
        n_dropped++;
      end else if (ctl && staging[0] == cpr_pkg::CODE_RETX) begin
        n_replay++;
        case (last_reply)
          cpr_pkg::LR_ACK:    push_reply(cpr_pkg::CODE_ACK, cpr_pkg::CRC_ACK);
          cpr_pkg::LR_GIVEUP: push_reply(cpr_pkg::CODE_GIVEUP, cpr_pkg::CRC_GIVEUP);
          default: begin
            push(cpr_pkg::KIND_TX, 8'h00, 1'b0);
            push(cpr_pkg::KIND_TX, 8'h00, 1'b0);
            push(cpr_pkg::KIND_TX, 8'h00, 1'b1);
          end
        endcase
      end else begin
        store_frame(b);
        last_reply = cpr_pkg::LR_ACK;
        push_reply(cpr_pkg::CODE_ACK, cpr_pkg::CRC_ACK);
        n_ack++;
      end
    end else if (retry_count < max_retries) begin
      retry_count++;
      push_reply(cpr_pkg::CODE_RETX, cpr_pkg::CRC_RETX);
      n_retx++;
    end else begin
      retry_count = '0;
      last_reply  = cpr_pkg::LR_GIVEUP;
      push_reply(cpr_pkg::CODE_GIVEUP, cpr_pkg::CRC_GIVEUP);
      n_giveup++;
    end
  endfunction

  function void note_word(logic func, logic [7:0] b);
    words_in++;
    if (func) begin
      pop_oldest();
      return;
    end
    case (rx_phase)
      cpr_pkg::PH_ID: begin
        frame_id    = b;
        running_crc = crc8_next(8'h00, b);
        rx_phase    = cpr_pkg::PH_LEN;
      end
      cpr_pkg::PH_LEN: begin
        frame_len   = b;
        running_crc = crc8_next(running_crc, b);
        data_count  = '0;
        if (b == 8'h00) rx_phase = cpr_pkg::PH_CRC;
        else rx_phase = cpr_pkg::PH_DATA;
      end
      cpr_pkg::PH_DATA: begin
        if (data_count < cpr_pkg::DATA_MAX) staging[data_count] = b;
        running_crc = crc8_next(running_crc, b);
        data_count++;
        if (data_count >= frame_len) rx_phase = cpr_pkg::PH_CRC;
      end
      default: begin
        rx_phase = cpr_pkg::PH_ID;
        close_frame(b);
      end
    endcase
  endfunction

  function void check_word(logic [1:0] kind, logic [7:0] data, logic last);
    out_word_t want;
    words_out++;
    if (expected_words.size() == 0) begin
      errors++;
      $display("%0t: unexpected word: expected none, got kind %0d byte %02h last %0b",
               $time, kind, data, last);
      return;
    end
    want = expected_words.pop_front();
    if (want.kind !== kind || want.data !== data || want.last !== last) begin
      errors++;
      $display("%0t: mismatch: expected kind %0d byte %02h last %0b, %s",
               $time, want.kind, want.data, want.last,
               $sformatf("got kind %0d byte %02h last %0b", kind, data, last));
    end
  endfunction
endclass

module tb_crc8_packet_receiver_with_ring;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_WORDS = 300;
  localparam logic [2:0] ADDR_MAX_RETRIES = 3'd0;
  localparam logic [2:0] ADDR_UNUSED      = 3'd4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  packet_ring_scoreboard sb;

  crc8_packet_receiver_with_ring DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_kind_o, out_byte_o, out_last_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic f, input logic [7:0] b);
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(f, b);
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input int fill,
                            input logic bad, input logic pop_inside);
    logic [7:0] crc, b;
    int pop_at, i;
    crc = crc8_next(8'h00, id);
    send_word(1'b0, id);
    crc = crc8_next(crc, len);
    send_word(1'b0, len);
    pop_at = pop_inside ? $urandom_range(len) : -1;
    for (i = 0; i <= len; i++) begin
      if (i == pop_at) send_word(1'b1, 8'($urandom));
      if (i < len) begin
        b = (fill < 0) ? 8'($urandom) : 8'(fill);
        crc = crc8_next(crc, b);
        send_word(1'b0, b);
      end
    end
    if (bad) crc = crc ^ (8'h01 << $urandom_range(7));
    send_word(1'b0, crc);
  endtask

  task automatic drain(input int extra);
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic realign();
    while (sb.rx_phase != cpr_pkg::PH_ID) send_word(1'b0, 8'($urandom));
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_MAX_RETRIES) sb.max_retries = data[7:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check_retries();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_RETRIES;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== sb.max_retries) begin
      sb.errors++;
      $display("%0t: max_retries read back: expected %02h, got %02h",
               $time, sb.max_retries, prdata[7:0]);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(input int words, input int pop_pct);
    int start, sel, len;
    start = sb.words_in;
    while (sb.words_in - start < words) begin
      sel = $urandom_range(99);
      if (sel < pop_pct) begin
        send_word(1'b1, 8'($urandom));
      end else if (sel < pop_pct + 6) begin
        send_frame(8'h00, cpr_pkg::CTL_LEN,
                   $urandom_range(1) ? cpr_pkg::CODE_RETX : cpr_pkg::CODE_ACK,
                   $urandom_range(5) == 0, 1'b0);
      end else if (sel < pop_pct + 11) begin
        send_word(1'b0, 8'($urandom));
      end else if (sel < pop_pct + 13) begin
        drain(0);
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(24, 17) : $urandom_range(6, 0);
        send_frame(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom), 8'(len), -1,
                   $urandom_range(4) == 0, $urandom_range(9) == 0);
      end
    end
    realign();
    drain(DRAIN_CYCLES);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    apb_check_retries();

    // Opening cases: empty ring, replay before any reply, zero length, bad CRC,
    // replay of an ack, a dropped ack, an id-0 data frame and a pop mid-frame.
    send_word(1'b1, 8'h00);
    send_frame(8'h00, cpr_pkg::CTL_LEN, cpr_pkg::CODE_RETX, 1'b0, 1'b0);
    send_frame(8'hFF, 8'h00, -1, 1'b0, 1'b0);
    send_frame(8'h00, 8'h00, -1, 1'b1, 1'b0);
    send_frame(8'h00, cpr_pkg::CTL_LEN, cpr_pkg::CODE_RETX, 1'b0, 1'b0);
    send_frame(8'h00, cpr_pkg::CTL_LEN, cpr_pkg::CODE_ACK, 1'b0, 1'b0);
    send_frame(8'h00, cpr_pkg::CTL_LEN, 8'hFF, 1'b0, 1'b1);
    send_word(1'b1, 8'hFF);
    send_word(1'b1, 8'h5A);
    run_random(RANDOM_WORDS / 5, 20);

    apb_write(ADDR_MAX_RETRIES, 32'd0);
    apb_check_retries();
    stall_pct = 55;
    run_random(RANDOM_WORDS / 5, 20);

    apb_write(ADDR_MAX_RETRIES, 32'd255);
    apb_check_retries();
    stall_pct = 0;
    idle_pct  = 55;
    send_frame(8'h5A, 8'd48, -1, 1'b0, 1'b0);
    run_random(RANDOM_WORDS / 5, 20);

    apb_write(ADDR_UNUSED, $urandom);
    apb_write(ADDR_MAX_RETRIES, $urandom_range(254, 1));
    apb_check_retries();
    stall_pct = 37;
    idle_pct  = 37;
    run_random(RANDOM_WORDS / 5, 40);

    apb_write(ADDR_MAX_RETRIES, 32'd1);
    apb_check_retries();
    stall_pct = 0;
    idle_pct  = 0;
    run_random(RANDOM_WORDS / 5, 15);

    $display("Covered %0d input words and %0d result words %s",
             sb.words_in, sb.words_out, "over five retry limits and idling mixes.");
    $display("Frames: %0d acked, %0d retransmit requests, %0d give-ups, %0d replays, %s",
             sb.n_ack, sb.n_retx, sb.n_giveup, sb.n_replay,
             $sformatf("%0d acks dropped; pops: %0d packets, %0d empty.",
                       sb.n_dropped, sb.n_pop, sb.n_empty));
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
